/* design/slac_pkg.sv */
`timescale 1ns / 1ps

package slac_pkg;

    localparam int ENTRIES_DEF = 64;

    localparam int KEY_W   = 64;
    localparam int SIZE_W  = 32;
    localparam int TIME_W  = 48;
    localparam int BYTES_W = 40;
    localparam int CNT_W   = 48;
    localparam int SUM_W   = 64;
    localparam int EVC_W   = 7;

    localparam logic [BYTES_W-1:0] CAP_RESET = 40'd5368709120;

    // Entry update applied by the cell whose index matches the write index.
    typedef enum logic [1:0] {
        WR_NONE,
        WR_TIME,
        WR_CLEAR,
        WR_FILL
    } wr_op_t;

    typedef struct packed {
        wr_op_t              op;
        logic [KEY_W-1:0]    key;
        logic [SIZE_W-1:0]   size;
        logic [TIME_W-1:0]   atime;
    } wr_t;

    // Scan token that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic                vld;
        logic                found;
        logic                vany;
        logic [TIME_W-1:0]   vtime;
        logic [SIZE_W-1:0]   vsize;
        logic                freeany;
    } scan_t;

endpackage

/* design/slac_if.sv */
`timescale 1ns / 1ps

interface slac_req_if;
    logic                          valid;
    logic                          ready;
    logic [slac_pkg::KEY_W-1:0]    object_key;
    logic [slac_pkg::SIZE_W-1:0]   object_size;
    logic [slac_pkg::TIME_W-1:0]   access_time;

    modport source (output valid, output object_key, output object_size,
                    output access_time, input ready);
    modport sink   (input valid, input object_key, input object_size,
                    input access_time, output ready);
endinterface

interface slac_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic                          inserted;
    logic [slac_pkg::EVC_W-1:0]    evicted_count;
    logic [slac_pkg::BYTES_W-1:0]  bytes_in_use;
    logic [slac_pkg::CNT_W-1:0]    requests_total;
    logic [slac_pkg::CNT_W-1:0]    hits_total;
    logic [slac_pkg::SUM_W-1:0]    requested_bytes_total;
    logic [slac_pkg::SUM_W-1:0]    hit_bytes_total;

    modport source (output valid, output hit, output inserted, output evicted_count,
                    output bytes_in_use, output requests_total, output hits_total,
                    output requested_bytes_total, output hit_bytes_total,
                    input ready);
    modport sink   (input valid, input hit, input inserted, input evicted_count,
                    input bytes_in_use, input requests_total, input hits_total,
                    input requested_bytes_total, input hit_bytes_total,
                    output ready);
endinterface

interface slac_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [slac_pkg::BYTES_W-1:0]  capacity_bytes;

    modport source (output valid, output capacity_bytes, input ready);
    modport sink   (input valid, input capacity_bytes, output ready);
endinterface

/* design/slac_cell.sv */
`timescale 1ns / 1ps

// One cache slot. It holds an entry and folds itself into the scan token
// as the token passes by.
module slac_cell #(
    parameter int ENTRIES = slac_pkg::ENTRIES_DEF,
    parameter int IDX     = 0,
    localparam int IW     = $clog2(ENTRIES)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [slac_pkg::KEY_W-1:0]   req_key,
    input  slac_pkg::wr_t                wr,
    input  logic [IW-1:0]                wr_idx,
    input  slac_pkg::scan_t              scan_in,
    input  logic [IW-1:0]                fidx_in,
    input  logic [IW-1:0]                vidx_in,
    input  logic [IW-1:0]                freeidx_in,
    output slac_pkg::scan_t              scan_out,
    output logic [IW-1:0]                fidx_out,
    output logic [IW-1:0]                vidx_out,
    output logic [IW-1:0]                freeidx_out
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic                          valid_reg;
    logic [slac_pkg::KEY_W-1:0]    key_reg;
    logic [slac_pkg::SIZE_W-1:0]   size_reg;
    logic [slac_pkg::TIME_W-1:0]   time_reg;

    logic            scan_vld_reg;
    slac_pkg::scan_t scan_reg;
    logic [IW-1:0]   fidx_reg;
    logic [IW-1:0]   vidx_reg;
    logic [IW-1:0]   freeidx_reg;

    logic            match;
    logic            take_v;
    logic            take_f;
    logic            sel;
    slac_pkg::scan_t scan_next;

    assign sel   = (wr_idx == MY_IDX);
    assign match = valid_reg && (key_reg == req_key);
    assign take_v = valid_reg && (!scan_in.vany || (time_reg < scan_in.vtime) ||
                    ((time_reg == scan_in.vtime) && (size_reg > scan_in.vsize)));
    assign take_f = !valid_reg && !scan_in.freeany;

    always_comb
    begin
        scan_next         = scan_in;
        scan_next.found   = scan_in.found | match;
        scan_next.freeany = scan_in.freeany | take_f;
        if (take_v)
        begin
            scan_next.vany  = 1'b1;
            scan_next.vtime = time_reg;
            scan_next.vsize = size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            scan_vld_reg <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= scan_in.vld;
            if (sel)
            begin
                case (wr.op)
                    slac_pkg::WR_CLEAR: valid_reg <= 1'b0;
                    slac_pkg::WR_FILL:  valid_reg <= 1'b1;
                    default:            valid_reg <= valid_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        fidx_reg    <= (!scan_in.found && match) ? MY_IDX : fidx_in;
        vidx_reg    <= take_v ? MY_IDX : vidx_in;
        freeidx_reg <= take_f ? MY_IDX : freeidx_in;
        if (sel)
        begin
            case (wr.op)
                slac_pkg::WR_TIME:
                begin
                    time_reg <= wr.atime;
                end
                slac_pkg::WR_FILL:
                begin
                    key_reg  <= wr.key;
                    size_reg <= wr.size;
                    time_reg <= wr.atime;
                end
                default:
                begin
                    time_reg <= time_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        scan_out     = scan_reg;
        scan_out.vld = scan_vld_reg;
    end

    assign fidx_out    = fidx_reg;
    assign vidx_out    = vidx_reg;
    assign freeidx_out = freeidx_reg;

endmodule

/* design/size_aware_lru_object_cache.sv */
`timescale 1ns / 1ps

// Channel | Modport | Direction | Moves
// --------+---------+-----------+-----------------------------------------------
// req     | sink    | in        | object_key, object_size, access_time
// rsp     | source  | out       | hit, inserted, evicted_count, bytes and counters
// cfg     | sink    | in        | capacity_bytes (always ready)
//
// A scan pass walks the row of ENTRIES cells, one cell per cycle, between a
// launch state and a decision state. A request needs one pass, plus one more
// pass per evicted entry. Its result is loaded into the output register from
// the done state after the last pass is decided, and the next request transfer
// can be taken in the same cycle in which that result is first offered.
// Reset is asynchronous and clears all slot valid bits at once; no clearing
// pass is needed. A new request transfer is taken as soon as the previous
// result sits in the output register, and a stalled rsp holds the block only
// when a second result is ready to be loaded.
module size_aware_lru_object_cache #(
    parameter int ENTRIES = slac_pkg::ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    slac_req_if.sink          req,
    slac_rsp_if.source        rsp,
    slac_cfg_if.sink          cfg
);

    localparam int IW = $clog2(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [slac_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [slac_pkg::SIZE_W-1:0]  size_reg, size_next;
    logic [slac_pkg::TIME_W-1:0]  time_reg, time_next;
    logic [slac_pkg::BYTES_W-1:0] cap_reg, cap_next;
    logic [slac_pkg::BYTES_W-1:0] occ_reg, occ_next;
    logic [slac_pkg::CNT_W-1:0]   reqcnt_reg, reqcnt_next;
    logic [slac_pkg::CNT_W-1:0]   hitcnt_reg, hitcnt_next;
    logic [slac_pkg::SUM_W-1:0]   reqbytes_reg, reqbytes_next;
    logic [slac_pkg::SUM_W-1:0]   hitbytes_reg, hitbytes_next;
    logic [slac_pkg::EVC_W-1:0]   evc_reg, evc_next;
    logic                         hit_reg, hit_next;
    logic                         ins_reg, ins_next;

    slac_pkg::scan_t              res_reg, res_next;
    logic [IW-1:0]                rfidx_reg, rfidx_next;
    logic [IW-1:0]                rvidx_reg, rvidx_next;
    logic [IW-1:0]                rfree_reg, rfree_next;

    logic                         out_vld_reg, out_vld_next;
    logic                         o_hit_reg, o_hit_next;
    logic                         o_ins_reg, o_ins_next;
    logic [slac_pkg::EVC_W-1:0]   o_evc_reg, o_evc_next;
    logic [slac_pkg::BYTES_W-1:0] o_occ_reg, o_occ_next;
    logic [slac_pkg::CNT_W-1:0]   o_reqcnt_reg, o_reqcnt_next;
    logic [slac_pkg::CNT_W-1:0]   o_hitcnt_reg, o_hitcnt_next;
    logic [slac_pkg::SUM_W-1:0]   o_reqbytes_reg, o_reqbytes_next;
    logic [slac_pkg::SUM_W-1:0]   o_hitbytes_reg, o_hitbytes_next;

    slac_pkg::wr_t                wr;
    logic [IW-1:0]                wr_idx;

    slac_pkg::scan_t              scan_head;
    slac_pkg::scan_t              chain_scan [ENTRIES+1];
    logic [IW-1:0]                chain_fidx [ENTRIES+1];
    logic [IW-1:0]                chain_vidx [ENTRIES+1];
    logic [IW-1:0]                chain_free [ENTRIES+1];

    logic                         over;
    logic                         fits;

    // The token enters the first cell empty; the start state launches it.
    always_comb
    begin
        scan_head     = '0;
        scan_head.vld = (state_reg == S_START);
    end

    assign chain_scan[0] = scan_head;
    assign chain_fidx[0] = '0;
    assign chain_vidx[0] = '0;
    assign chain_free[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        slac_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .req_key     (key_reg),
            .wr          (wr),
            .wr_idx      (wr_idx),
            .scan_in     (chain_scan[g]),
            .fidx_in     (chain_fidx[g]),
            .vidx_in     (chain_vidx[g]),
            .freeidx_in  (chain_free[g]),
            .scan_out    (chain_scan[g+1]),
            .fidx_out    (chain_fidx[g+1]),
            .vidx_out    (chain_vidx[g+1]),
            .freeidx_out (chain_free[g+1])
        );
    end

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid                 = out_vld_reg;
    assign rsp.hit                   = o_hit_reg;
    assign rsp.inserted              = o_ins_reg;
    assign rsp.evicted_count         = o_evc_reg;
    assign rsp.bytes_in_use          = o_occ_reg;
    assign rsp.requests_total        = o_reqcnt_reg;
    assign rsp.hits_total            = o_hitcnt_reg;
    assign rsp.requested_bytes_total = o_reqbytes_reg;
    assign rsp.hit_bytes_total       = o_hitbytes_reg;

    // Admission needs the size strictly below capacity. The eviction test
    // needs one extra bit because occupied plus size can pass 2^40.
    assign fits = ({8'd0, size_reg} < cap_reg);
    assign over = (({1'b0, occ_reg} + {9'd0, size_reg}) > {1'b0, cap_reg});

    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        size_next       = size_reg;
        time_next       = time_reg;
        cap_next        = cap_reg;
        occ_next        = occ_reg;
        reqcnt_next     = reqcnt_reg;
        hitcnt_next     = hitcnt_reg;
        reqbytes_next   = reqbytes_reg;
        hitbytes_next   = hitbytes_reg;
        evc_next        = evc_reg;
        hit_next        = hit_reg;
        ins_next        = ins_reg;
        res_next        = res_reg;
        rfidx_next      = rfidx_reg;
        rvidx_next      = rvidx_reg;
        rfree_next      = rfree_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        o_hit_next      = o_hit_reg;
        o_ins_next      = o_ins_reg;
        o_evc_next      = o_evc_reg;
        o_occ_next      = o_occ_reg;
        o_reqcnt_next   = o_reqcnt_reg;
        o_hitcnt_next   = o_hitcnt_reg;
        o_reqbytes_next = o_reqbytes_reg;
        o_hitbytes_next = o_hitbytes_reg;
        wr              = '0;
        wr.op           = slac_pkg::WR_NONE;
        wr.key          = key_reg;
        wr.size         = size_reg;
        wr.atime        = time_reg;
        wr_idx          = '0;

        if (cfg.valid)
        begin
            cap_next = cfg.capacity_bytes;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next      = req.object_key;
                    size_next     = req.object_size;
                    time_next     = req.access_time;
                    reqcnt_next   = reqcnt_reg + 1'b1;
                    reqbytes_next = reqbytes_reg + {32'd0, req.object_size};
                    evc_next      = '0;
                    hit_next      = 1'b0;
                    ins_next      = 1'b0;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (chain_scan[ENTRIES].vld)
                begin
                    res_next   = chain_scan[ENTRIES];
                    rfidx_next = chain_fidx[ENTRIES];
                    rvidx_next = chain_vidx[ENTRIES];
                    rfree_next = chain_free[ENTRIES];
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (res_reg.found)
                begin
                    // Hit: refresh the timestamp only; the stored size stays.
                    wr.op         = slac_pkg::WR_TIME;
                    wr_idx        = rfidx_reg;
                    hit_next      = 1'b1;
                    hitcnt_next   = hitcnt_reg + 1'b1;
                    hitbytes_next = hitbytes_reg + {32'd0, size_reg};
                end
                else if (fits)
                begin
                    if ((over || !res_reg.freeany) && res_reg.vany)
                    begin
                        // Evict the oldest entry and scan again.
                        wr.op      = slac_pkg::WR_CLEAR;
                        wr_idx     = rvidx_reg;
                        occ_next   = occ_reg - {8'd0, res_reg.vsize};
                        evc_next   = evc_reg + 1'b1;
                        state_next = S_START;
                    end
                    else if (res_reg.freeany)
                    begin
                        wr.op    = slac_pkg::WR_FILL;
                        wr_idx   = rfree_reg;
                        occ_next = occ_reg + {8'd0, size_reg};
                        ins_next = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next    = 1'b1;
                    o_hit_next      = hit_reg;
                    o_ins_next      = ins_reg;
                    o_evc_next      = evc_reg;
                    o_occ_next      = occ_reg;
                    o_reqcnt_next   = reqcnt_reg;
                    o_hitcnt_next   = hitcnt_reg;
                    o_reqbytes_next = reqbytes_reg;
                    o_hitbytes_next = hitbytes_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cap_reg      <= slac_pkg::CAP_RESET;
            occ_reg      <= '0;
            reqcnt_reg   <= '0;
            hitcnt_reg   <= '0;
            reqbytes_reg <= '0;
            hitbytes_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            occ_reg      <= occ_next;
            reqcnt_reg   <= reqcnt_next;
            hitcnt_reg   <= hitcnt_next;
            reqbytes_reg <= reqbytes_next;
            hitbytes_reg <= hitbytes_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_next_hold:
        begin
            key_reg        <= key_next;
            size_reg       <= size_next;
            time_reg       <= time_next;
            evc_reg        <= evc_next;
            hit_reg        <= hit_next;
            ins_reg        <= ins_next;
            res_reg        <= res_next;
            rfidx_reg      <= rfidx_next;
            rvidx_reg      <= rvidx_next;
            rfree_reg      <= rfree_next;
            o_hit_reg      <= o_hit_next;
            o_ins_reg      <= o_ins_next;
            o_evc_reg      <= o_evc_next;
            o_occ_reg      <= o_occ_next;
            o_reqcnt_reg   <= o_reqcnt_next;
            o_hitcnt_reg   <= o_hitcnt_next;
            o_reqbytes_reg <= o_reqbytes_next;
            o_hitbytes_reg <= o_hitbytes_next;
        end
    end

endmodule

/* design/slac_checker.sv */
`timescale 1ns / 1ps

module slac_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          hit,
    input logic                          inserted,
    input logic [slac_pkg::EVC_W-1:0]    evicted_count,
    input logic [slac_pkg::BYTES_W-1:0]  bytes_in_use
);

    // A hit never admits or evicts anything.
    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && hit |-> !inserted && (evicted_count == '0))
        else $error("hit result also reports insertion or eviction");

    // A stalled result stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn while stalled");

    // The block never takes a request in the cycle right after taking one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one is in progress");

    // A stalled result does not change its occupancy figure.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(bytes_in_use))
        else $error("bytes_in_use changed while stalled");

endmodule

bind size_aware_lru_object_cache slac_checker u_slac_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .hit           (rsp.hit),
    .inserted      (rsp.inserted),
    .evicted_count (rsp.evicted_count),
    .bytes_in_use  (rsp.bytes_in_use)
);
